@@ rtl/mpc_pkg.sv @@
// shared types, codes and constants of the memory pattern checker
package mpc_pkg;

   localparam int MEM_BYTES_DEFAULT = 262144;
   localparam int QUEUE_DEPTH       = 2;

   localparam int CSR_WIDTH  = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int ADDR_OUT_W = 18;

   localparam logic [CSR_IDX_W-1:0] REG_SEQ_START   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SEQ_STEP    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BLANK_LIMIT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CHIP_ID     = 2'd3;

   localparam logic [7:0]  SEQ_START_RESET   = 8'd0;
   localparam logic [7:0]  SEQ_STEP_RESET    = 8'd1;
   localparam logic [15:0] BLANK_LIMIT_RESET = 16'd16;
   localparam logic [4:0]  CHIP_ID_RESET     = 5'd0;

   localparam logic [15:0] BLANK_RUN_MAX = 16'hFFFF;

   localparam logic [1:0] KIND_MATCH = 2'd0;
   localparam logic [1:0] KIND_BIT   = 2'd1;
   localparam logic [1:0] KIND_ABORT = 2'd2;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       pass_start;
   } req_type;

   typedef struct packed {
      logic [1:0]            error_kind;
      logic [ADDR_OUT_W-1:0] byte_address;
      logic [2:0]            bit_index;
      logic                  read_bit;
      logic [7:0]            expected_byte;
      logic [4:0]            chip_tag;
      logic                  unresponsive;
      logic                  last;
   } rsp_type;

   // one classified request waiting for the back end
   typedef struct packed {
      logic [1:0]            kind;
      logic [ADDR_OUT_W-1:0] byte_address;
      logic [7:0]            rx_byte;
      logic [7:0]            wrong;
      logic [7:0]            expected_byte;
      logic [4:0]            chip_tag;
      logic                  unresponsive;
   } job_type;

endpackage

@@ rtl/mpc_front.sv @@
// front end: configuration registers, pass state and classification of each request
module mpc_front import mpc_pkg::*; #(
   parameter int MEM_BYTES = MEM_BYTES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0] csr_data,
   input  logic                 req_fire,
   input  req_type              req_data,
   output job_type              job
);

   localparam int AW = $clog2(MEM_BYTES + 1);
   localparam logic [AW-1:0] MEM_COUNT = AW'(MEM_BYTES);

   logic [7:0]  seq_start_ff, seq_step_ff;
   logic [15:0] blank_limit_ff;
   logic [4:0]  chip_id_ff;

   logic [7:0]    expected_ff, expected_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [15:0]   blank_ff, blank_in;
   logic          aborted_ff, aborted_in;
   logic          unresp_ff, unresp_in;

   logic [7:0]           exp_cur;
   logic [AW-1:0]        addr_cur, addr_inc;
   logic [15:0]          blank_cur;
   logic                 aborted_cur;
   logic [AW+ADDR_OUT_W-1:0] addr_wide;
   logic [7:0]           wrong;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_start_ff   <= SEQ_START_RESET;
         seq_step_ff    <= SEQ_STEP_RESET;
         blank_limit_ff <= BLANK_LIMIT_RESET;
         chip_id_ff     <= CHIP_ID_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_SEQ_START:   seq_start_ff   <= csr_data[7:0];
            REG_SEQ_STEP:    seq_step_ff    <= csr_data[7:0];
            REG_BLANK_LIMIT: blank_limit_ff <= csr_data[15:0];
            REG_CHIP_ID:     chip_id_ff     <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      // a pass start restarts the sequence before the byte is looked at
      exp_cur     = req_data.pass_start ? seq_start_ff : expected_ff;
      addr_cur    = req_data.pass_start ? '0 : addr_ff;
      blank_cur   = req_data.pass_start ? '0 : blank_ff;
      aborted_cur = req_data.pass_start ? 1'b0 : aborted_ff;
      addr_inc    = addr_cur + AW'(1);
      addr_wide   = {{ADDR_OUT_W{1'b0}}, addr_cur};
      wrong       = req_data.rx_byte ^ exp_cur;

      expected_in = exp_cur;
      addr_in     = addr_cur;
      blank_in    = blank_cur;
      aborted_in  = aborted_cur;
      unresp_in   = unresp_ff;

      job.kind          = KIND_MATCH;
      job.byte_address  = addr_wide[ADDR_OUT_W-1:0];
      job.rx_byte       = req_data.rx_byte;
      job.wrong         = '0;
      job.expected_byte = exp_cur;
      job.chip_tag      = chip_id_ff;

      if (!aborted_cur && addr_cur < MEM_COUNT) begin
         if (req_data.rx_byte == 8'h00) begin
            if (blank_cur != BLANK_RUN_MAX) begin
               blank_in = blank_cur + 16'd1;
            end
         end else begin
            blank_in = '0;
         end
         if (blank_in >= blank_limit_ff) begin
            aborted_in = 1'b1;
            unresp_in  = 1'b1;
            job.kind   = KIND_ABORT;
         end else begin
            if (addr_inc == MEM_COUNT) begin
               unresp_in = 1'b0;
            end
            if (wrong != 8'h00) begin
               job.kind  = KIND_BIT;
               job.wrong = wrong;
            end
            expected_in = exp_cur + seq_step_ff;
            addr_in     = addr_inc;
         end
      end
      job.unresponsive = unresp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= '0;
         addr_ff     <= '0;
         blank_ff    <= '0;
         aborted_ff  <= 1'b0;
         unresp_ff   <= 1'b0;
      end else if (req_fire) begin
         expected_ff <= expected_in;
         addr_ff     <= addr_in;
         blank_ff    <= blank_in;
         aborted_ff  <= aborted_in;
         unresp_ff   <= unresp_in;
      end
   end

endmodule

@@ rtl/mpc_queue.sv @@
// short queue of classified requests between front and back end
module mpc_queue import mpc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output job_type head
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] COUNT_FULL = CW'(QUEUE_DEPTH);

   job_type       slot_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full      = (count_ff == COUNT_FULL);
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/mpc_back.sv @@
// back end: expands one classified request into its records, one per cycle while not stalled
module mpc_back import mpc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_ready,
   input  job_type job_head,
   output logic    job_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic       busy_ff, busy_in;
   job_type    work_ff, work_in;
   logic [7:0] remain_ff, remain_in;

   logic [7:0] low_bit;
   logic [2:0] bit_idx;
   logic       is_last;
   logic       rsp_fire;

   always_comb begin
      low_bit = remain_ff & (~remain_ff + 8'd1);
      bit_idx = '0;
      for (int i = 0; i < 8; i++) begin
         if (low_bit[i]) begin
            bit_idx = 3'(i);
         end
      end
      is_last = ((remain_ff & ~low_bit) == 8'h00);
   end

   assign rsp_valid = busy_ff;
   assign rsp_fire  = busy_ff && !rsp_stall;
   assign job_pop   = job_ready && (!busy_ff || (rsp_fire && is_last));

   always_comb begin
      rsp_data.error_kind    = work_ff.kind;
      rsp_data.byte_address  = work_ff.byte_address;
      rsp_data.bit_index     = bit_idx;
      rsp_data.read_bit      = (work_ff.kind == KIND_BIT) ? work_ff.rx_byte[bit_idx] : 1'b0;
      rsp_data.expected_byte = work_ff.expected_byte;
      rsp_data.chip_tag      = work_ff.chip_tag;
      rsp_data.unresponsive  = work_ff.unresponsive;
      rsp_data.last          = is_last;
   end

   always_comb begin
      busy_in   = busy_ff;
      work_in   = work_ff;
      remain_in = remain_ff;
      if (job_pop) begin
         busy_in   = 1'b1;
         work_in   = job_head;
         remain_in = job_head.wrong;
      end else if (rsp_fire) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            remain_in = remain_ff & ~low_bit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff   <= work_in;
      remain_ff <= remain_in;
   end

endmodule

@@ rtl/memory_pattern_checker.sv @@
// top level of the memory pattern checker
// Checks bytes read back from a memory against start + address * step (mod 256) and
// reports one record per wrong bit, lowest bit first, or a single record for a byte
// that matched, was ignored or aborted the pass on a run of zero bytes. While the
// result port is not stalled, a clean read-back streams at one byte per clock; a
// byte with n wrong bits holds the result port for its n records, since the
// back end emits one record per clock. A two-entry queue sits between the front end,
// which classifies each request as it arrives, and the back end. Reset is immediate,
// with no clearing pass.
module memory_pattern_checker import mpc_pkg::*; #(
   parameter int MEM_BYTES = MEM_BYTES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0] csr_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data
);

   job_type new_job, head_job;
   logic    req_fire, q_full, q_not_empty, q_pop;

   assign req_stall = q_full;
   assign req_fire  = req_valid && !q_full;

   mpc_front #(
      .MEM_BYTES(MEM_BYTES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .req_fire (req_fire),
      .req_data (req_data),
      .job      (new_job)
   );

   mpc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_fire),
      .push_data(new_job),
      .pop      (q_pop),
      .full     (q_full),
      .not_empty(q_not_empty),
      .head     (head_job)
   );

   mpc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .job_ready(q_not_empty),
      .job_head (head_job),
      .job_pop  (q_pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule
